// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset.
`define DMSP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmsp assertion failed");
// Next-cycle implication, clocked on clk, off during reset.
`define DMSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmsp assertion failed");
`else
`define DMSP_ASSERT(label, ante, cons)
`define DMSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/dmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types and constants of the decimal money string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsp_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  localparam int AMT_W  = 64;
  localparam int MAC_W  = AMT_W + 4;
  localparam int FC_W   = 2;       // holds up to three fraction digits
  localparam int POW_W  = 10;      // holds 10^3
  localparam int PROD_W = AMT_W + POW_W;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CL_DIGIT,
    CL_MINUS,
    CL_POINT,
    CL_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    PH_SIGN  = 2'd0,
    PH_WHOLE = 2'd1,
    PH_FRAC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       has_char;
    logic       last;
    cls_t       cls;
    logic [3:0] digit;
  } entry_t;

  typedef struct packed {
    logic [AMT_W-1:0] mag;
    logic             neg;
    logic [FC_W-1:0]  fcount;
    logic             bad;
  } rec_t;

endpackage

`default_nettype wire

// ===== sv/dmsp_front.sv =====
// ----------------------------------------------------------------------------
// dmsp_front
// Accepts characters, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_char_code,
  input  wire logic             in_has_char,
  input  wire logic             in_last,
  output logic                  q_valid_o,
  output dmsp_pkg::entry_t      q_data_o,
  input  wire logic             q_pop_i
);

  dmsp_pkg::entry_t                  slot_r [dmsp_pkg::QDEPTH];
  logic [dmsp_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dmsp_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dmsp_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  dmsp_pkg::entry_t                  ent;
  logic [7:0]                        dif;
  logic                              push, pop;

  always_comb begin
    dif          = in_char_code - dmsp_pkg::CH_ZERO;
    ent.has_char = in_has_char;
    ent.last     = in_last;
    ent.digit    = dif[3:0];
    if (in_char_code >= dmsp_pkg::CH_ZERO && in_char_code <= dmsp_pkg::CH_NINE) begin
      ent.cls = dmsp_pkg::CL_DIGIT;
    end else if (in_char_code == dmsp_pkg::CH_MINUS) begin
      ent.cls = dmsp_pkg::CL_MINUS;
    end else if (in_char_code == dmsp_pkg::CH_POINT) begin
      ent.cls = dmsp_pkg::CL_POINT;
    end else begin
      ent.cls = dmsp_pkg::CL_OTHER;
    end
  end

  assign in_stall  = !rst_n || (cnt_r == dmsp_pkg::QCNT_W'(dmsp_pkg::QDEPTH));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_r != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_data_o  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + dmsp_pkg::QCNT_W'(push) - dmsp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= ent;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dmsp_back.sv =====
// ----------------------------------------------------------------------------
// dmsp_back
// Parser state machine: folds queued characters into a magnitude and emits
// one end-of-string record per string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmsp_back #(
  parameter int FRACTION_DIGITS = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid_i,
  input  wire dmsp_pkg::entry_t q_data_i,
  output logic                  q_pop_o,
  output logic                  rec_valid_o,
  output dmsp_pkg::rec_t        rec_o,
  input  wire logic             rec_ready_i
);

  localparam int FCW = $clog2(FRACTION_DIGITS + 1);

  dmsp_pkg::phase_t             phase_r, phase_nxt;
  logic [dmsp_pkg::AMT_W-1:0]   acc_r, acc_nxt;
  logic                         neg_r, neg_nxt;
  logic [FCW-1:0]               fcount_r, fcount_nxt;
  logic                         failed_r, failed_nxt;
  logic                         rec_valid_r, rec_valid_nxt;
  dmsp_pkg::rec_t               rec_r, rec_nxt;

  dmsp_pkg::phase_t             ph_n;
  logic [dmsp_pkg::AMT_W-1:0]   acc_n;
  logic                         neg_n, fail_n;
  logic [FCW-1:0]               fc_n;
  logic [dmsp_pkg::MAC_W-1:0]   mac;
  logic                         mac_ovf, is_digit;
  logic                         ent_end, rec_slot, take;

  assign ent_end  = !q_data_i.has_char || q_data_i.last;
  assign rec_slot = !rec_valid_r || rec_ready_i;
  assign take     = q_valid_i && (!ent_end || rec_slot);
  assign q_pop_o  = take;
  assign is_digit = (q_data_i.cls == dmsp_pkg::CL_DIGIT);

  // acc * 10 + digit; anything past bit 62 is an overflow
  assign mac     = (dmsp_pkg::MAC_W'(acc_r) << 3) + (dmsp_pkg::MAC_W'(acc_r) << 1)
                 + dmsp_pkg::MAC_W'(q_data_i.digit);
  assign mac_ovf = |mac[dmsp_pkg::MAC_W-1:dmsp_pkg::AMT_W-1];

  always_comb begin
    ph_n   = phase_r;
    acc_n  = acc_r;
    neg_n  = neg_r;
    fc_n   = fcount_r;
    fail_n = failed_r;
    if (q_data_i.has_char && !failed_r) begin
      case (phase_r)
        dmsp_pkg::PH_WHOLE: begin
          if (is_digit) begin
            if (mac_ovf) fail_n = 1'b1;
            else         acc_n  = mac[dmsp_pkg::AMT_W-1:0];
          end else if (q_data_i.cls == dmsp_pkg::CL_POINT) begin
            ph_n = dmsp_pkg::PH_FRAC;
          end else begin
            fail_n = 1'b1;
          end
        end
        dmsp_pkg::PH_FRAC: begin
          if (is_digit && fcount_r < FCW'(FRACTION_DIGITS)) begin
            if (mac_ovf) fail_n = 1'b1;
            else         acc_n  = mac[dmsp_pkg::AMT_W-1:0];
            fc_n = fcount_r + 1'b1;
          end else begin
            fail_n = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            if (mac_ovf) fail_n = 1'b1;
            else         acc_n  = mac[dmsp_pkg::AMT_W-1:0];
            ph_n = dmsp_pkg::PH_WHOLE;
          end else if (q_data_i.cls == dmsp_pkg::CL_MINUS) begin
            neg_n = 1'b1;
            ph_n  = dmsp_pkg::PH_WHOLE;
          end else begin
            fail_n = 1'b1;
          end
        end
      endcase
    end

    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    fcount_nxt = fcount_r;
    failed_nxt = failed_r;
    if (take) begin
      if (ent_end) begin
        phase_nxt  = dmsp_pkg::PH_SIGN;
        acc_nxt    = '0;
        neg_nxt    = 1'b0;
        fcount_nxt = '0;
        failed_nxt = 1'b0;
      end else begin
        phase_nxt  = ph_n;
        acc_nxt    = acc_n;
        neg_nxt    = neg_n;
        fcount_nxt = fc_n;
        failed_nxt = fail_n;
      end
    end

    rec_nxt.mag    = acc_n;
    rec_nxt.neg    = neg_n;
    rec_nxt.fcount = dmsp_pkg::FC_W'(fc_n);
    rec_nxt.bad    = fail_n || (ph_n == dmsp_pkg::PH_FRAC && fc_n == '0);

    if (take && ent_end) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_ready_i) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dmsp_pkg::PH_SIGN;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      fcount_r    <= '0;
      failed_r    <= 1'b0;
      rec_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      fcount_r    <= fcount_nxt;
      failed_r    <= failed_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ent_end) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_valid_o = rec_valid_r;
  assign rec_o       = rec_r;

  `DMSP_ASSERT_NEXT(a_end_clears, take && ent_end, phase_r == dmsp_pkg::PH_SIGN && !failed_r && acc_r == '0)
  `DMSP_ASSERT(a_frac_count_phase, fcount_r != '0, phase_r == dmsp_pkg::PH_FRAC)
  `DMSP_ASSERT_NEXT(a_fail_sticky, failed_r && !(take && ent_end), failed_r)
  `DMSP_ASSERT_NEXT(a_rec_hold, rec_valid_r && !rec_ready_i, rec_valid_r && $stable(rec_r))

endmodule

`default_nettype wire

// ===== sv/dmsp_finish.sv =====
// ----------------------------------------------------------------------------
// dmsp_finish
// Scales the magnitude to full fraction precision, checks range and sign,
// and holds the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_finish #(
  parameter int FRACTION_DIGITS = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rec_valid_i,
  input  wire dmsp_pkg::rec_t                rec_i,
  output logic                               rec_ready_o,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [dmsp_pkg::AMT_W-1:0]  out_amount,
  output logic                               out_ok
);

  logic [dmsp_pkg::FC_W-1:0]    missing;
  logic [dmsp_pkg::PROD_W-1:0]  mag_w;
  logic [dmsp_pkg::PROD_W-1:0]  prod;
  logic                         prod_ovf;

  logic                         a_valid_r, a_valid_nxt;
  logic [dmsp_pkg::AMT_W-1:0]   a_mag_r;
  logic                         a_neg_r, a_bad_r;
  logic                         o_valid_r, o_valid_nxt;
  logic [dmsp_pkg::AMT_W-1:0]   o_amount_r;
  logic                         o_ok_r;
  logic                         out_ready, a_ready;

  assign out_ready   = !o_valid_r || !out_stall;
  assign a_ready     = !a_valid_r || out_ready;
  assign rec_ready_o = a_ready;

  // scale by ten for each fraction digit not given
  assign missing  = dmsp_pkg::FC_W'(FRACTION_DIGITS) - rec_i.fcount;

  always_comb begin
    mag_w = dmsp_pkg::PROD_W'(rec_i.mag);
    case (missing)
      2'd0:    prod = mag_w;
      2'd1:    prod = (mag_w << 3) + (mag_w << 1);
      2'd2:    prod = (mag_w << 6) + (mag_w << 5) + (mag_w << 2);
      default: prod = (mag_w << 10) - (mag_w << 4) - (mag_w << 3);
    endcase
  end

  assign prod_ovf = |prod[dmsp_pkg::PROD_W-1:dmsp_pkg::AMT_W-1];

  always_comb begin
    a_valid_nxt = a_ready ? rec_valid_i : a_valid_r;
    o_valid_nxt = out_ready ? a_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && rec_valid_i) begin
      a_mag_r <= prod[dmsp_pkg::AMT_W-1:0];
      a_neg_r <= rec_i.neg;
      // a minus sign on a zero value is rejected
      a_bad_r <= rec_i.bad || prod_ovf || (rec_i.neg && rec_i.mag == '0);
    end
    if (out_ready && a_valid_r) begin
      if (a_bad_r) begin
        o_amount_r <= '0;
      end else if (a_neg_r) begin
        o_amount_r <= '0 - a_mag_r;
      end else begin
        o_amount_r <= a_mag_r;
      end
      o_ok_r <= !a_bad_r;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_amount = o_amount_r;
  assign out_ok     = o_ok_r;

endmodule

`default_nettype wire

// ===== sv/decimal_money_string_parser_core.sv =====
// ----------------------------------------------------------------------------
// decimal_money_string_parser_core
// Streams an amount string in and returns its value in units of 10^-FRACTION_DIGITS (hundredths by default).
// ----------------------------------------------------------------------------
// Takes one character per item and accepts a new item every clock cycle while in_stall is low.
// A string ends at an item with in_has_char=1 and in_last=1, or at any item
// with in_has_char=0 (alone, the empty string, which gives 0). One result
// follows each string: out_amount in units of 10^-FRACTION_DIGITS,
// two's complement, with out_ok=1, or 0 with out_ok=0 on a syntax error,
// a point with no fraction digits, a negative zero or 64-bit overflow.
// Characters pass a two-entry queue into the parser, whose combinational
// multiply-add by ten sets the rate of one character per cycle while no
// stall holds it; the result of a string goes through the parser record,
// the scaling register and the output register before out_valid rises.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_money_string_parser_core #(
  parameter int FRACTION_DIGITS = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_char_code,
  input  wire logic                          in_has_char,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [dmsp_pkg::AMT_W-1:0]  out_amount,
  output logic                               out_ok
);

  logic              q_valid, q_pop;
  dmsp_pkg::entry_t  q_data;
  logic              rec_valid, rec_ready;
  dmsp_pkg::rec_t    rec;

  dmsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_has_char  (in_has_char),
    .in_last      (in_last),
    .q_valid_o    (q_valid),
    .q_data_o     (q_data),
    .q_pop_i      (q_pop)
  );

  dmsp_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .rec_valid_o (rec_valid),
    .rec_o       (rec),
    .rec_ready_i (rec_ready)
  );

  dmsp_finish #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_valid_i (rec_valid),
    .rec_i       (rec),
    .rec_ready_o (rec_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_amount  (out_amount),
    .out_ok      (out_ok)
  );

endmodule

`default_nettype wire
